// ===== hw/rtl/psreg_pkg.sv =====
// ----------------------------------------------------------------------------
// psreg_pkg
// Shared types and constants of the phase shift regulator.
// ----------------------------------------------------------------------------
package psreg_pkg;

  localparam int unsigned MUL_W = 26;

  localparam logic [MUL_W-1:0] RECIP_22  = 26'd762601;    // ceil(2^24 / 22)
  localparam logic [MUL_W-1:0] RECIP_10  = 26'd26843546;  // ceil(2^28 / 10)
  localparam logic [MUL_W-1:0] DEG_SCALE = 26'd45;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_B0        = 2'd1;
  localparam logic [1:0] REG_B1        = 2'd2;
  localparam logic [1:0] REG_MAX_PHASE = 2'd3;

  localparam logic [1:0] LIM_NONE = 2'd0;
  localparam logic [1:0] LIM_MAX  = 2'd1;
  localparam logic [1:0] LIM_ZERO = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VMUL,
    ST_ERR,
    ST_B0,
    ST_B1,
    ST_SAT,
    ST_HMUL,
    ST_HOLD,
    ST_DMUL,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_VOLT,
    MUL_B0,
    MUL_B1,
    MUL_HOLD,
    MUL_DEG
  } mul_sel_e;

  typedef struct packed {
    logic     ld_in;
    logic     ld_err;
    logic     ld_acc;
    logic     ld_sat;
    logic     ld_hold;
    logic     ld_out;
    mul_sel_e mul_sel;
  } ctl_t;

endpackage

// ===== hw/rtl/psreg_mul.sv =====
// ----------------------------------------------------------------------------
// psreg_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module psreg_mul (
  input  logic                                 clk_i,
  input  logic signed [psreg_pkg::MUL_W-1:0]   a_i,
  input  logic signed [psreg_pkg::MUL_W-1:0]   b_i,
  output logic signed [2*psreg_pkg::MUL_W-1:0] p_o
);
  import psreg_pkg::*;

  logic signed [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/psreg_seq.sv =====
// ----------------------------------------------------------------------------
// psreg_seq
// Sequencer that steps one request through the shared multiplier.
// ----------------------------------------------------------------------------
module psreg_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             hold_i,
  input  logic             out_free_i,
  output logic             in_ready_o,
  output psreg_pkg::ctl_t  ctl_o
);
  import psreg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = hold_i ? ST_HMUL : ST_VMUL;
        end
      end
      ST_VMUL: state_d = ST_ERR;
      ST_ERR:  state_d = ST_B0;
      ST_B0:   state_d = ST_B1;
      ST_B1:   state_d = ST_SAT;
      ST_SAT:  state_d = ST_DMUL;
      ST_HMUL: state_d = ST_HOLD;
      ST_HOLD: state_d = ST_DMUL;
      ST_DMUL: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ctl_o         = '0;
    ctl_o.mul_sel = MUL_DEG;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctl_o.ld_in = in_valid_i;
      end
      ST_VMUL: ctl_o.mul_sel = MUL_VOLT;
      ST_ERR:  ctl_o.ld_err = 1'b1;
      ST_B0:   ctl_o.mul_sel = MUL_B0;
      ST_B1: begin
        ctl_o.mul_sel = MUL_B1;
        ctl_o.ld_acc  = 1'b1;
      end
      ST_SAT:  ctl_o.ld_sat = 1'b1;
      ST_HMUL: ctl_o.mul_sel = MUL_HOLD;
      ST_HOLD: ctl_o.ld_hold = 1'b1;
      ST_DMUL: ctl_o.mul_sel = MUL_DEG;
      ST_DONE: ctl_o.ld_out = out_free_i;
      default: ctl_o.mul_sel = MUL_DEG;
    endcase
  end

endmodule

// ===== hw/rtl/phase_shift_pi_regulator_top.sv =====
// ----------------------------------------------------------------------------
// phase_shift_pi_regulator_top
// Velocity-form PI regulator that turns a converter sample into a phase shift.
// ----------------------------------------------------------------------------
// A request steps through the sequencer states from acceptance to a loaded
// result (a shorter path when the sample falls below the soft-start
// threshold), plus any wait for the result register to drain. The single
// 26x26 multiplier is used in turn for volts scaling, both gain products,
// the hold value and the degree conversion. The input side is ready only
// while the sequencer is idle; the result sits in an output register until taken.
module phase_shift_pi_regulator_top #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [17:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] adc_sample_i,
  input  logic [14:0]            target_volts_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [16:0]            phase_degrees_o,
  output logic                   soft_start_hold_o,
  output logic [1:0]             limit_status_o
);
  import psreg_pkg::*;

  localparam int unsigned CW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam int unsigned NW = SAMPLE_BITS + 19;

  logic [11:0]        thr_q;
  logic signed [17:0] b0_q;
  logic signed [17:0] b1_q;
  logic [15:0]        mpf_q;

  logic signed [31:0] y_q;
  logic signed [16:0] last_err_q;

  logic [SAMPLE_BITS-1:0] adc_q;
  logic [14:0]            tgt_q;
  logic                   hold_q;
  logic signed [16:0]     e_q;
  logic signed [35:0]     acc_q;
  logic [23:0]            yc_q;
  logic [1:0]             status_q;

  logic        out_valid_q;
  logic [16:0] deg_out_q;
  logic        hold_out_q;
  logic [1:0]  status_out_q;

  logic                      hold_in;
  logic                      out_free;
  ctl_t                      ctl;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] prod;

  logic [NW-1:0]      vnum;
  logic [18:0]        vq;
  logic [14:0]        volts;
  logic signed [16:0] e_new;
  logic signed [35:0] sum;
  logic signed [31:0] ysat;
  logic [23:0]        maxq;
  logic [23:0]        hold_val;
  logic [32:0]        dsum;
  logic [19:0]        dq;
  logic [16:0]        deg;

  assign hold_in  = CW'(adc_sample_i) < CW'(thr_q);
  assign out_free = !out_valid_q || out_ready_i;

  psreg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .hold_i     (hold_in),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctl_o      (ctl)
  );

  psreg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 12'd200;
      b0_q  <= 18'sd3269;
      b1_q  <= -18'sd3265;
      mpf_q <= 16'd16384;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thr_q <= cfg_data_i[11:0];
        REG_B0:        b0_q  <= $signed(cfg_data_i);
        REG_B1:        b1_q  <= $signed(cfg_data_i);
        REG_MAX_PHASE: mpf_q <= cfg_data_i[15:0];
        default:       thr_q <= thr_q;
      endcase
    end
  end

  // adc * 409600 + (11 << SAMPLE_BITS), then drop SAMPLE_BITS; divide by 22 after
  assign vnum = (NW'(adc_q) << 18) + (NW'(adc_q) << 17) + (NW'(adc_q) << 14)
              + (NW'(11) << SAMPLE_BITS);
  assign vq   = vnum[SAMPLE_BITS +: 19];
  assign maxq = {mpf_q, 8'd0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul_sel)
      MUL_VOLT: begin
        mul_a = $signed(MUL_W'(vq));
        mul_b = $signed(RECIP_22);
      end
      MUL_B0: begin
        mul_a = MUL_W'(b0_q);
        mul_b = MUL_W'(e_q);
      end
      MUL_B1: begin
        mul_a = MUL_W'(b1_q);
        mul_b = MUL_W'(last_err_q);
      end
      MUL_HOLD: begin
        mul_a = $signed(MUL_W'(maxq) + MUL_W'(5));
        mul_b = $signed(RECIP_10);
      end
      MUL_DEG: begin
        mul_a = $signed(MUL_W'(yc_q));
        mul_b = $signed(DEG_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign volts    = prod[24 +: 15];
  assign e_new    = $signed({2'b00, tgt_q}) - $signed({2'b00, volts});
  assign hold_val = {3'd0, prod[28 +: 21]};
  assign sum      = acc_q + prod[35:0];

  always_comb begin
    if (sum > 36'sd2147483647) begin
      ysat = 32'sh7FFFFFFF;
    end else if (sum < -36'sd2147483648) begin
      ysat = 32'sh80000000;
    end else begin
      ysat = sum[31:0];
    end
  end

  assign dsum = prod[32:0] + 33'd4096;
  assign dq   = dsum[32:13];
  assign deg  = (dq[19:17] != 3'd0) ? 17'h1FFFF : dq[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q        <= '0;
      last_err_q <= '0;
    end else if (ctl.ld_sat) begin
      y_q        <= ysat;
      last_err_q <= e_q;
    end else if (ctl.ld_hold) begin
      y_q        <= $signed({8'd0, hold_val});
      last_err_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_in) begin
      adc_q  <= adc_sample_i;
      tgt_q  <= target_volts_i;
      hold_q <= hold_in;
    end
    if (ctl.ld_err) begin
      e_q <= e_new;
    end
    if (ctl.ld_acc) begin
      acc_q <= 36'(y_q) + prod[35:0];
    end
    if (ctl.ld_sat) begin
      if ($signed({ysat[31], ysat}) >= $signed({9'd0, maxq})) begin
        yc_q     <= maxq;
        status_q <= LIM_MAX;
      end else if (ysat <= 32'sd0) begin
        yc_q     <= '0;
        status_q <= LIM_ZERO;
      end else begin
        yc_q     <= ysat[23:0];
        status_q <= LIM_NONE;
      end
    end
    if (ctl.ld_hold) begin
      yc_q     <= hold_val;
      status_q <= LIM_NONE;
    end
    if (ctl.ld_out) begin
      deg_out_q    <= deg;
      hold_out_q   <= hold_q;
      status_out_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign phase_degrees_o   = deg_out_q;
  assign soft_start_hold_o = hold_out_q;
  assign limit_status_o    = status_out_q;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> limit_status_o != 2'd3)
    else $error("undefined limit status");

  a_hold_unclamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && soft_start_hold_o |-> limit_status_o == LIM_NONE)
    else $error("hold result reports a clamp");

  a_zero_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && limit_status_o == LIM_ZERO |-> phase_degrees_o == 17'd0)
    else $error("zero clamp with nonzero phase");

endmodule
